/* rtl/core/gbn_pkg.sv */
`default_nettype none
package gbn_pkg;

  localparam int SEQ_W     = 32;
  localparam int MAX_WIN   = 64;
  localparam int PAY_BYTES = 20;

  // input item kinds
  localparam logic [1:0] MODE_MSG = 2'd0;
  localparam logic [1:0] MODE_ACK = 2'd1;
  localparam logic [1:0] MODE_TMO = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_CORR  = 3'd2;
  localparam logic [2:0] ST_STALE = 3'd3;
  localparam logic [2:0] ST_TMO   = 3'd4;

  // timer commands
  localparam logic [1:0] TC_NONE    = 2'd0;
  localparam logic [1:0] TC_START   = 2'd1;
  localparam logic [1:0] TC_STOP    = 2'd2;
  localparam logic [1:0] TC_RESTART = 2'd3;

  // register addresses (index in paddr[2])
  localparam logic REG_WINDOW  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  typedef struct packed {
    logic       capture;
    logic       grp;
    logic       store;
    logic       ack_apply;
    logic       rd;
    logic       rd_tmo;
    logic       nts_inc;
    logic       tmo_clr;
    logic       tmo_inc;
    logic       load;
    logic       pkt;
    logic       last;
    logic [1:0] tcmd;
    logic [2:0] status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       full;
    logic       ck_ok;
    logic       ack_good;
    logic       ack_hits_nts;
    logic       send_ok;
    logic       send_more;
    logic       at_base;
    logic       tmo_zero;
    logic       tmo_last;
  } stat_t;

  typedef struct packed {
    logic        pkt;
    logic [31:0] seq;
    logic [31:0] ck;
    logic [63:0] low;
    logic [63:0] mid;
    logic [31:0] high;
    logic [1:0]  tcmd;
    logic [15:0] dur;
    logic [2:0]  status;
    logic        last;
  } res_t;

  // sum of five bytes taken as signed
  function automatic logic signed [10:0] sum5(input logic [39:0] b);
    logic signed [10:0] s;
    s = '0;
    for (int i = 0; i < 5; i++) begin
      s = s + 11'(signed'(b[8*i +: 8]));
    end
    return s;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/go_back_n_sender_top.sv */
// Go-Back-N sender.
// An item is taken only in idle; then come byte sums and the check, and each packet
// after that is a ring read, then a load into the result register, through the single
// ring read port. The next item waits until its last result is loaded; stalls add.
// Reset (synchronous, rst_n low): pointers to 1, window 8, timeout 15; ring not cleared.
`default_nettype none
module go_back_n_sender_top #(
  parameter int BUFFER_DEPTH = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input items
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [255:0] in_tdata,   // pkt_seq, pkt_ack, pkt_checksum,
                                        // payload_low, payload_mid, payload_high
  input  wire logic [1:0]   in_tuser,   // mode
  // results
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [247:0]      out_tdata,  // out_seq, out_checksum, out_payload_low,
                                        // out_payload_mid, out_payload_high,
                                        // timer_cmd, timer_duration, status, pad
  output logic              out_tuser,  // packet_valid
  output logic              out_tlast,  // last
  // config
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import gbn_pkg::*;

  logic [6:0]  window_r;
  logic [15:0] timeout_r;
  logic        cfg_wr;
  cmd_t        cmd;
  stat_t       st;
  res_t        res;

  // APB: no wait states; register picked by address bit 2
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_r}
                                                    : {25'd0, window_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= 7'd8;
      timeout_r <= 16'd15;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_WINDOW) window_r  <= cfg_pwdata[6:0];
      else                            timeout_r <= cfg_pwdata[15:0];
    end
  end

  // sequencer: one item at a time, output register decoupled from input side
  gbn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_tvalid && in_tready),
    .out_tready (out_tready),
    .st         (st),
    .in_tready  (in_tready),
    .out_valid  (out_tvalid),
    .cmd        (cmd)
  );

  // pointers, checksum, packet ring and result register
  gbn_dp #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_mode          (in_tuser),
    .in_data          (in_tdata),
    .win_limit        (window_r),
    .timeout_interval (timeout_r),
    .st               (st),
    .res              (res)
  );

  assign out_tdata = {3'd0, res.status, res.dur, res.tcmd, res.high, res.mid,
                      res.low, res.ck, res.seq};
  assign out_tuser = res.pkt;
  assign out_tlast = res.last;

endmodule
`default_nettype wire

/* rtl/core/gbn_ctrl.sv */
`default_nettype none
module gbn_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic          out_tready,
  input  wire gbn_pkg::stat_t st,
  output logic               in_tready,
  output logic               out_valid,
  output gbn_pkg::cmd_t      cmd
);
  import gbn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_CHECK, S_SEND_START, S_SEND_RD, S_SEND_LD,
    S_TMO_RD, S_TMO_LD, S_SINGLE
  } state_t;

  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       ack_r, ack_nxt;
  logic       started_r, started_nxt;
  logic [2:0] status_r, status_nxt;
  logic [1:0] tcmd_r, tcmd_nxt;
  logic       free;

  assign free      = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    ack_nxt     = ack_r;
    started_nxt = started_r;
    status_nxt  = status_r;
    tcmd_nxt    = tcmd_r;
    cmd         = '0;
    cmd.status  = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SUM;
        end
      end
      S_SUM: begin
        cmd.grp   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        ack_nxt    = 1'b0;
        status_nxt = ST_OK;
        tcmd_nxt   = TC_NONE;
        state_nxt  = S_SINGLE;
        case (st.mode)
          MODE_MSG: begin
            if (st.full) begin
              status_nxt = ST_FULL;
            end else begin
              cmd.store = 1'b1;
              state_nxt = S_SEND_START;
            end
          end
          MODE_ACK: begin
            if (!st.ck_ok) begin
              status_nxt = ST_CORR;
            end else if (!st.ack_good) begin
              status_nxt = ST_STALE;
            end else begin
              cmd.ack_apply = 1'b1;
              if (st.ack_hits_nts) begin
                ack_nxt   = 1'b1;
                state_nxt = S_SEND_START;
              end else begin
                tcmd_nxt = TC_START;
              end
            end
          end
          MODE_TMO: begin
            status_nxt  = ST_TMO;
            tcmd_nxt    = TC_START;
            cmd.tmo_clr = 1'b1;
            if (!st.tmo_zero) state_nxt = S_TMO_RD;
          end
          default: ;
        endcase
      end
      S_SEND_START: begin
        if (st.send_ok) begin
          started_nxt = st.at_base;
          state_nxt   = S_SEND_RD;
        end else begin
          tcmd_nxt  = ack_r ? TC_STOP : TC_NONE;
          state_nxt = S_SINGLE;
        end
      end
      S_SEND_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SEND_LD;
      end
      S_SEND_LD: begin
        if (free) begin
          cmd.load    = 1'b1;
          cmd.pkt     = 1'b1;
          cmd.nts_inc = 1'b1;
          cmd.last    = !st.send_more;
          if (!st.send_more) begin
            cmd.tcmd  = ack_r ? TC_RESTART : (started_r ? TC_START : TC_NONE);
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SEND_RD;
          end
        end
      end
      S_TMO_RD: begin
        cmd.rd     = 1'b1;
        cmd.rd_tmo = 1'b1;
        state_nxt  = S_TMO_LD;
      end
      S_TMO_LD: begin
        if (free) begin
          cmd.load    = 1'b1;
          cmd.pkt     = 1'b1;
          cmd.tmo_inc = 1'b1;
          cmd.last    = st.tmo_last;
          if (st.tmo_last) begin
            cmd.tcmd  = TC_START;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_TMO_RD;
          end
        end
      end
      S_SINGLE: begin
        if (free) begin
          cmd.load  = 1'b1;
          cmd.last  = 1'b1;
          cmd.tcmd  = tcmd_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.load)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ack_r       <= 1'b0;
      started_r   <= 1'b0;
      status_r    <= ST_OK;
      tcmd_r      <= TC_NONE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ack_r       <= ack_nxt;
      started_r   <= started_nxt;
      status_r    <= status_nxt;
      tcmd_r      <= tcmd_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || out_tready))
    else $error("result overwritten before taken");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("item taken while busy");
  a_pkt_last_tmo: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && cmd.last && status_r == ST_TMO) |-> (cmd.tcmd == TC_START))
    else $error("timeout without timer start");

endmodule
`default_nettype wire

/* rtl/core/gbn_dp.sv */
`default_nettype none
module gbn_dp #(
  parameter int BUFFER_DEPTH = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire gbn_pkg::cmd_t  cmd,
  input  wire logic [1:0]     in_mode,
  input  wire logic [255:0]   in_data,
  input  wire logic [6:0]     win_limit,
  input  wire logic [15:0]    timeout_interval,
  output gbn_pkg::stat_t      st,
  output gbn_pkg::res_t       res
);
  import gbn_pkg::*;

  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int DW    = $clog2(BUFFER_DEPTH + 1);
  localparam int WMAX  = (BUFFER_DEPTH < MAX_WIN) ? BUFFER_DEPTH : MAX_WIN;
  localparam int MW    = 7;

  // ring index of s0 + d, given the index of s0; d never exceeds the depth
  function automatic logic [IDX_W-1:0] idx_at(input logic [31:0] s0,
                                               input logic [IDX_W-1:0] i0,
                                               input logic [DW-1:0] d);
    logic [32:0] s;
    logic [DW:0] t;
    s = {1'b0, s0} + 33'(d);
    t = (DW+1)'(i0) + (DW+1)'(d);
    if (t >= (DW+1)'(BUFFER_DEPTH)) t = t - (DW+1)'(BUFFER_DEPTH);
    if (s[32]) return s[IDX_W-1:0];
    return t[IDX_W-1:0];
  endfunction

  logic [1:0]   mode_r;
  logic [31:0]  seq_r, ack_r, ck_r;
  logic [159:0] pay_r;
  logic signed [10:0] g_r [4];

  logic [31:0]  base_r, nts_r, nf_r;
  logic [IDX_W-1:0] base_idx_r, nts_idx_r, nf_idx_r;
  logic [MW-1:0] tmo_i_r;

  logic [191:0] mem [BUFFER_DEPTH];
  logic [191:0] rd_data_r;
  logic [31:0]  rd_seq_r;

  logic [6:0]   w_eff;
  logic [31:0]  a_diff, b_diff, acked, ack1, ack_step, ck_calc, tmo_seq;
  logic signed [12:0] tot;
  logic [MW-1:0] cnt;
  logic [IDX_W-1:0] rd_idx, tmo_idx;

  always_comb begin
    if (win_limit == 7'd0)             w_eff = 7'd1;
    else if (win_limit > 7'(WMAX))     w_eff = 7'(WMAX);
    else                               w_eff = win_limit;
  end

  assign a_diff = nf_r - nts_r;
  assign b_diff = nts_r - base_r;
  assign acked  = ack_r - base_r;
  assign ack1   = ack_r + 32'd1;
  assign ack_step = ack1 - base_r;
  assign tot    = 13'(g_r[0]) + 13'(g_r[1]) + 13'(g_r[2]) + 13'(g_r[3]);
  assign ck_calc = ((mode_r == MODE_MSG) ? nf_r : (seq_r + ack_r))
                 + {{19{tot[12]}}, tot};
  assign cnt     = (b_diff > 32'(MAX_WIN)) ? MW'(MAX_WIN) : b_diff[MW-1:0];
  assign tmo_seq = base_r + 32'(tmo_i_r);
  assign tmo_idx = idx_at(base_r, base_idx_r, DW'(tmo_i_r));
  assign rd_idx  = cmd.rd_tmo ? tmo_idx : nts_idx_r;

  always_comb begin
    st.mode         = mode_r;
    st.full         = (nf_r - base_r) >= 32'(BUFFER_DEPTH);
    st.ck_ok        = (ck_calc == ck_r);
    st.ack_good     = acked < b_diff;
    st.ack_hits_nts = (ack1 == nts_r);
    st.send_ok      = (a_diff != 32'd0) && (a_diff <= 32'(BUFFER_DEPTH))
                    && (b_diff < 32'(w_eff));
    st.send_more    = (a_diff != 32'd1) && ((a_diff - 32'd1) <= 32'(BUFFER_DEPTH))
                    && ((b_diff + 32'd1) < 32'(w_eff));
    st.at_base      = (nts_r == base_r);
    st.tmo_zero     = (b_diff == 32'd0);
    st.tmo_last     = ((tmo_i_r + MW'(1)) == cnt);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      seq_r  <= in_data[31:0];
      ack_r  <= in_data[63:32];
      ck_r   <= in_data[95:64];
      pay_r  <= in_data[255:96];
    end
    if (cmd.grp) begin
      for (int k = 0; k < 4; k++) g_r[k] <= sum5(pay_r[40*k +: 40]);
    end
    if (cmd.store) mem[nf_idx_r] <= {ck_calc, pay_r};
    if (cmd.rd) begin
      rd_data_r <= mem[rd_idx];
      rd_seq_r  <= cmd.rd_tmo ? tmo_seq : nts_r;
    end
    if (cmd.load) begin
      res.pkt    <= cmd.pkt;
      res.seq    <= cmd.pkt ? rd_seq_r : 32'd0;
      res.ck     <= cmd.pkt ? rd_data_r[191:160] : 32'd0;
      res.low    <= cmd.pkt ? rd_data_r[63:0] : 64'd0;
      res.mid    <= cmd.pkt ? rd_data_r[127:64] : 64'd0;
      res.high   <= cmd.pkt ? rd_data_r[159:128] : 32'd0;
      res.tcmd   <= cmd.tcmd;
      res.dur    <= (cmd.tcmd == TC_START || cmd.tcmd == TC_RESTART)
                    ? timeout_interval : 16'd0;
      res.status <= cmd.status;
      res.last   <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= 32'd1;
      nts_r      <= 32'd1;
      nf_r       <= 32'd1;
      base_idx_r <= IDX_W'(1 % BUFFER_DEPTH);
      nts_idx_r  <= IDX_W'(1 % BUFFER_DEPTH);
      nf_idx_r   <= IDX_W'(1 % BUFFER_DEPTH);
      tmo_i_r    <= '0;
    end else begin
      if (cmd.store) begin
        nf_r     <= nf_r + 32'd1;
        nf_idx_r <= idx_at(nf_r, nf_idx_r, DW'(1));
      end
      if (cmd.ack_apply) begin
        base_r     <= ack1;
        base_idx_r <= idx_at(base_r, base_idx_r, ack_step[DW-1:0]);
      end
      if (cmd.nts_inc) begin
        nts_r     <= nts_r + 32'd1;
        nts_idx_r <= idx_at(nts_r, nts_idx_r, DW'(1));
      end
      if (cmd.tmo_clr)      tmo_i_r <= '0;
      else if (cmd.tmo_inc) tmo_i_r <= tmo_i_r + MW'(1);
    end
  end

  a_sent_stored: assert property (@(posedge clk) disable iff (!rst_n)
    (nts_r - base_r) <= (nf_r - base_r))
    else $error("sent beyond stored");
  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (nf_r - base_r) <= 32'(BUFFER_DEPTH))
    else $error("ring over-filled");
  a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> !st.full)
    else $error("store into full ring");

endmodule
`default_nettype wire

/* tb/tb_go_back_n_sender_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_go_back_n_sender_top;
  import gbn_pkg::*;

  // one result as the block should present it
  typedef struct packed {
    logic        pkt;
    logic [31:0] seq;
    logic [31:0] ck;
    logic [63:0] low;
    logic [63:0] mid;
    logic [31:0] high;
    logic [1:0]  tcmd;
    logic [15:0] dur;
    logic [2:0]  status;
    logic        last;
  } tx_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;   // pkt_seq, pkt_ack, pkt_checksum, payload low/mid/high
  logic [1:0]   in_tuser = '0;   // mode
  logic         out_tvalid;
  logic         out_tready = 1'b1;
  logic [247:0] out_tdata;       // seq, checksum, payload low/mid/high, tcmd, dur, status
  logic         out_tuser;       // packet_valid
  logic         out_tlast;       // last
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  localparam logic [2:0] ADDR_WINDOW  = 3'd0;
  localparam logic [2:0] ADDR_TIMEOUT = 3'd4;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  go_back_n_sender_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #4 clk = ~clk;

  // sender's own view of the block
  logic [6:0]  win_reg;
  logic [15:0] tmo_reg;
  logic [31:0] send_base, next_to_send, next_free;
  logic [63:0] ring_low [64];
  logic [63:0] ring_mid [64];
  logic [31:0] ring_high[64];
  logic [31:0] ring_ck  [64];

  tx_res_t pending_pkts[$];
  int      mismatches = 0;
  int      burst_left = 0;

  // 32-bit wrapping sum of seq, ack and the 20 payload bytes, each signed
  function automatic logic [31:0] pkt_sum(logic [31:0] seq, logic [31:0] ack,
                                          logic [63:0] lo, logic [63:0] mid,
                                          logic [31:0] hi);
    logic [159:0] bytes;
    logic [31:0]  s;
    bytes = {hi, mid, lo};
    s = seq + ack;
    for (int i = 0; i < 20; i++)
      s = s + {{24{bytes[8*i+7]}}, bytes[8*i +: 8]};
    return s;
  endfunction

  function automatic tx_res_t stored_pkt(logic [31:0] seq);
    tx_res_t r;
    r = '0;
    r.pkt  = 1'b1;
    r.seq  = seq;
    r.ck   = ring_ck[seq[5:0]];
    r.low  = ring_low[seq[5:0]];
    r.mid  = ring_mid[seq[5:0]];
    r.high = ring_high[seq[5:0]];
    return r;
  endfunction

  // works out every result of one accepted item and queues them
  task automatic predict_sender(logic [1:0] mode, logic [255:0] d);
    tx_res_t     res[$];
    tx_res_t     r;
    logic [31:0] seq, ack, ck, w, cnt;
    logic [63:0] lo, mid;
    logic [31:0] hi;
    logic [2:0]  st;
    logic [1:0]  tc;
    bit          started;
    seq = d[31:0]; ack = d[63:32]; ck = d[95:64];
    lo = d[159:96]; mid = d[223:160]; hi = d[255:224];
    st = ST_OK; tc = TC_NONE; started = 0;
    w = (win_reg == 0) ? 1 : (win_reg > 64) ? 64 : win_reg;
    case (mode)
      MODE_MSG: begin
        if (next_free - send_base >= 64) begin
          st = ST_FULL;
        end else begin
          ring_low[next_free[5:0]]  = lo;
          ring_mid[next_free[5:0]]  = mid;
          ring_high[next_free[5:0]] = hi;
          ring_ck[next_free[5:0]]   = pkt_sum(next_free, 0, lo, mid, hi);
          next_free++;
        end
      end
      MODE_ACK: begin
        if (ck != pkt_sum(seq, ack, lo, mid, hi)) st = ST_CORR;
        else if (ack - send_base >= next_to_send - send_base) st = ST_STALE;
        else begin
          send_base = ack + 1;
          tc = (send_base == next_to_send) ? TC_STOP : TC_START;
        end
      end
      MODE_TMO: begin
        cnt = next_to_send - send_base;
        if (cnt > 64) cnt = 64;
        for (int i = 0; i < cnt; i++) res.push_back(stored_pkt(send_base + i));
        st = ST_TMO; tc = TC_START;
      end
      default: ;
    endcase
    // window refill: after a stored message, or an ack that empties the window
    if ((mode == MODE_MSG && st == ST_OK) || (mode == MODE_ACK && tc == TC_STOP)) begin
      while (next_free != next_to_send && next_free - next_to_send <= 64 &&
             next_to_send - send_base < w && res.size() < 64) begin
        if (next_to_send == send_base) started = 1;
        res.push_back(stored_pkt(next_to_send));
        next_to_send++;
      end
      if (started) tc = (mode == MODE_MSG) ? TC_START : TC_RESTART;
    end
    if (res.size() == 0) res.push_back('0);
    for (int i = 0; i < res.size(); i++) begin
      r = res[i];
      r.status = st;
      if (i == res.size() - 1) begin
        r.tcmd = tc;
        r.dur  = (tc == TC_START || tc == TC_RESTART) ? tmo_reg : 16'd0;
        r.last = 1'b1;
      end
      pending_pkts.push_back(r);
    end
  endtask

  // one item: raised at the falling edge, predicted at acceptance, bursts and gaps
  task automatic send_item(logic [1:0] mode, logic [31:0] seq, logic [31:0] ack,
                           logic [31:0] ck, logic [63:0] lo, logic [63:0] mid,
                           logic [31:0] hi);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {hi, mid, lo, ck, ack, seq};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_sender(mode, {hi, mid, lo, ck, ack, seq});
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic send_msg(logic [63:0] lo, logic [63:0] mid, logic [31:0] hi);
    send_item(MODE_MSG, $urandom, $urandom, $urandom, lo, mid, hi);
  endtask

  // ack packet with a correct checksum, optionally spoilt
  task automatic send_ack(logic [31:0] ack, bit spoil);
    logic [31:0] seq;
    logic [63:0] lo, mid;
    logic [31:0] hi;
    seq = $urandom; lo = {$urandom, $urandom}; mid = {$urandom, $urandom}; hi = $urandom;
    send_item(MODE_ACK, seq, ack,
              pkt_sum(seq, ack, lo, mid, hi) ^ (spoil ? (32'd1 << $urandom_range(0, 31)) : 0),
              lo, mid, hi);
  endtask

  task automatic send_timeout();
    send_item(MODE_TMO, $urandom, $urandom, $urandom,
              {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
  endtask

  // hold off until every expected result has come, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_pkts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= addr; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr == ADDR_WINDOW) win_reg = val[6:0];
    else tmo_reg = val[15:0];
  endtask

  task automatic set_config(logic [6:0] win, logic [15:0] tmo);
    drain();
    cfg_write(ADDR_WINDOW, {25'd0, win});
    cfg_write(ADDR_TIMEOUT, {16'd0, tmo});
  endtask

  // payload extremes, corrupt and stale acks, idle timeout, ignored mode
  task automatic test_directed();
    send_timeout();                                  // nothing outstanding
    send_msg('0, '0, '0);
    send_msg('1, '1, '1);
    send_msg({8{8'h80}}, {8{8'h80}}, {4{8'h80}});
    send_msg({8{8'h7f}}, {8{8'h7f}}, {4{8'h7f}});
    send_ack(next_to_send, 0);                       // at next_to_send: stale
    send_ack(send_base - 1, 0);                      // below base: stale
    send_ack(send_base, 1);                          // corrupt
    send_ack(send_base, 0);                          // partial, timer start
    send_timeout();                                  // resend outstanding
    send_item(MODE_IGNORED, '1, '1, '1, '1, '1, '1);
    send_ack(32'h7fffffff, 0);
    send_ack(32'h80000000, 0);
    send_ack(next_to_send - 1, 0);                   // window emptied
  endtask

  // small window: an ack that empties it while packets wait
  task automatic test_window_refill();
    set_config(7'd2, 16'd1);
    repeat (4) send_msg({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
    send_ack(next_to_send - 1, 0);
    send_ack(next_to_send - 1, 0);
    send_timeout();
    send_ack(next_to_send - 1, 0);
  endtask

  // fill the ring without acks until messages are dropped, then recover
  task automatic test_ring_full();
    set_config(7'd8, 16'd65535);
    while (next_free - send_base < 64)
      send_msg({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
    send_msg('1, '0, '1);                            // dropped
    send_msg('0, '1, '0);                            // dropped
    while (send_base != next_free) send_ack(next_to_send - 1, 0);
  endtask

  // mostly well-formed traffic with noise
  task automatic test_random(int n_items);
    int          pick;
    logic [31:0] outst;
    for (int i = 0; i < n_items; i++) begin
      pick  = $urandom_range(0, 99);
      outst = next_to_send - send_base;
      if (pick < 45) begin
        send_msg({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      end else if (pick < 72 && outst != 0) begin
        send_ack(send_base + $urandom_range(0, outst - 1), 0);
      end else if (pick < 78) begin
        send_ack(send_base + $urandom_range(0, 3), 1);
      end else if (pick < 84) begin
        case ($urandom_range(0, 2))
          0: send_ack(next_to_send + $urandom_range(0, 3), 0);
          1: send_ack(send_base - 1 - $urandom_range(0, 3), 0);
          default: send_ack($urandom, 0);
        endcase
      end else if (pick < 96) begin
        send_timeout();
      end else begin
        send_item(MODE_IGNORED, $urandom, $urandom, $urandom,
                  {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      end
    end
  endtask

  // sweep of window settings, extremes and out-of-range values included
  task automatic test_window_sweep();
    set_config(7'd1, 16'd1);       test_random(50);
    set_config(7'd64, 16'd65535);  test_random(60);
    set_config(7'd0, 16'd300);     test_random(40);
    set_config(7'd127, 16'd15);    test_random(50);
    set_config(7'd8, 16'($urandom));    test_random(60);
    set_config(7'($urandom_range(2, 63)), 16'($urandom_range(1, 65535))); test_random(70);
  endtask

  // receiver readiness: free-running, random, periodic and sparse stretches
  int stall_cnt = 0;
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 1;
    case (stall_cnt[10:9])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= 1'($urandom_range(0, 1));
      2'd2: out_tready <= (stall_cnt[1:0] != 2'd3);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    tx_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[31:0], out_tdata[63:32], out_tdata[127:64],
             out_tdata[191:128], out_tdata[223:192], out_tdata[225:224],
             out_tdata[241:226], out_tdata[244:242], out_tlast};
      if (pending_pkts.size() == 0) begin
        mismatches++;
        if (mismatches < 40) $display("%t unexpected result: actual %p", $time, got);
      end else begin
        want = pending_pkts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches < 40)
            $display("%t result mismatch: expected %p actual %p", $time, want, got);
        end
      end
    end
  end

  initial begin
    win_reg = 7'd8; tmo_reg = 16'd15;
    send_base = 1; next_to_send = 1; next_free = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_window_refill();
    test_ring_full();
    test_window_sweep();
    drain();
    if (mismatches == 0 && pending_pkts.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // generous run limit
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
